@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the positional list engine RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Condition must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`endif

@@ hw/rtl/plst_pkg.sv @@
// Package for the positional list engine: operation and status codes,
// field widths and the structs passed between the sequencer, store and top.
// No dependencies.
package plst_pkg;

    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int ADDR_W  = 6;

    typedef enum logic [2:0] {
        OP_COUNT  = 3'd0,
        OP_INSERT = 3'd1,
        OP_DELETE = 3'd2,
        OP_SEARCH = 3'd3,
        OP_DUMP   = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_POS   = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [VAL_W-1:0]  wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_mem_req;

    typedef struct packed {
        t_status          status;
        logic [POS_W-1:0] entry_total;
        logic [POS_W-1:0] found_position;
        logic [VAL_W-1:0] entry_value;
        logic             last;
    } t_result;

endpackage

@@ hw/rtl/plst_store.sv @@
// Entry store of the positional list engine: one write port and one
// registered read port. Depends on plst_pkg.
module plst_store #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                        i_clk,
    input  plst_pkg::t_mem_req          i_mem_req,
    output logic [plst_pkg::VAL_W-1:0]  o_rd_data
);

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

    logic [plst_pkg::VAL_W-1:0] r_mem [LIST_DEPTH];
    logic [plst_pkg::VAL_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem_req.wr_en) begin
            r_mem[i_mem_req.wr_addr[AW-1:0]] <= i_mem_req.wr_data;
        end
    end

    // Read data holds while no read is issued, so a stalled step keeps it.
    always_ff @(posedge i_clk) begin
        if (i_mem_req.rd_en) begin
            r_rd_data <= r_mem[i_mem_req.rd_addr[AW-1:0]];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/plst_seq.sv @@
// Sequencer of the positional list engine: walks the store one entry per
// step for shifts, searches and dumps, and keeps the entry count.
// Depends on plst_pkg and assert_macros.svh.
`include "assert_macros.svh"

module plst_seq #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [2:0]                  i_operation,
    input  logic [plst_pkg::POS_W-1:0]  i_position,
    input  logic [plst_pkg::VAL_W-1:0]  i_value,
    input  logic [plst_pkg::VAL_W-1:0]  i_rd_data,
    output plst_pkg::t_mem_req          o_mem_req,
    input  logic                        i_out_free,
    output logic                        o_emit,
    output plst_pkg::t_result           o_result
);

    localparam logic [plst_pkg::POS_W-1:0] DepthCnt = plst_pkg::POS_W'(LIST_DEPTH);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_RD   = 4'b0010,
        S_USE  = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                      r_state, n_state;
    plst_pkg::t_op               r_op, n_op;
    logic [plst_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [plst_pkg::VAL_W-1:0]  r_val, n_val;
    logic [plst_pkg::POS_W-1:0]  r_idx, n_idx;
    logic [plst_pkg::POS_W-1:0]  r_count, n_count;
    logic                        r_have, n_have;
    plst_pkg::t_result           r_pend, n_pend;
    plst_pkg::t_result           result;

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_idx     = r_idx;
        n_count   = r_count;
        n_have    = r_have;
        n_pend    = r_pend;
        o_mem_req = '0;
        o_emit    = 1'b0;
        result    = r_pend;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_op   = plst_pkg::t_op'(i_operation);
                    n_pos  = i_position;
                    n_val  = i_value;
                    n_have = 1'b0;
                    n_pend = '{status: plst_pkg::ST_OK, entry_total: '0,
                               found_position: '0, entry_value: '0, last: 1'b1};
                    unique case (plst_pkg::t_op'(i_operation))
                        plst_pkg::OP_COUNT: begin
                            n_state = S_EMIT;
                        end
                        plst_pkg::OP_INSERT: begin
                            if (r_count >= DepthCnt) begin
                                n_pend.status = plst_pkg::ST_FULL;
                                n_state       = S_EMIT;
                            end else if (i_position == '0 ||
                                         i_position > r_count + 7'd1) begin
                                n_pend.status = plst_pkg::ST_BAD_POS;
                                n_state       = S_EMIT;
                            end else begin
                                n_idx   = r_count;
                                n_state = S_RD;
                            end
                        end
                        plst_pkg::OP_DELETE: begin
                            if (r_count == '0) begin
                                n_pend.status = plst_pkg::ST_EMPTY;
                                n_state       = S_EMIT;
                            end else if (i_position == '0 || i_position > r_count) begin
                                n_pend.status = plst_pkg::ST_BAD_POS;
                                n_state       = S_EMIT;
                            end else begin
                                n_idx   = i_position;
                                n_state = S_RD;
                            end
                        end
                        plst_pkg::OP_SEARCH, plst_pkg::OP_DUMP: begin
                            if (r_count == '0) begin
                                n_pend.status = plst_pkg::ST_EMPTY;
                                n_state       = S_EMIT;
                            end else begin
                                n_idx   = '0;
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            // Unknown operations are taken and dropped.
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end

            S_RD: begin
                unique case (r_op)
                    plst_pkg::OP_INSERT: begin
                        if (r_idx >= r_pos) begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = plst_pkg::ADDR_W'(r_idx - 7'd1);
                            n_state           = S_USE;
                        end else begin
                            o_mem_req.wr_en   = 1'b1;
                            o_mem_req.wr_addr = plst_pkg::ADDR_W'(r_pos - 7'd1);
                            o_mem_req.wr_data = r_val;
                            n_count           = r_count + 7'd1;
                            n_state           = S_EMIT;
                        end
                    end
                    plst_pkg::OP_DELETE: begin
                        if (r_idx < r_count) begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = plst_pkg::ADDR_W'(r_idx);
                            n_state           = S_USE;
                        end else begin
                            n_count = r_count - 7'd1;
                            n_state = S_EMIT;
                        end
                    end
                    plst_pkg::OP_SEARCH: begin
                        if (r_idx < r_count) begin
                            o_mem_req.rd_en   = 1'b1;
                            o_mem_req.rd_addr = plst_pkg::ADDR_W'(r_idx);
                            n_state           = S_USE;
                        end else if (r_have) begin
                            n_pend.last = 1'b1;
                            n_state     = S_EMIT;
                        end else begin
                            n_pend  = '{status: plst_pkg::ST_NOT_FOUND, entry_total: '0,
                                        found_position: '0, entry_value: '0, last: 1'b1};
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        o_mem_req.rd_en   = 1'b1;
                        o_mem_req.rd_addr = plst_pkg::ADDR_W'(r_idx);
                        n_state           = S_USE;
                    end
                endcase
            end

            S_USE: begin
                unique case (r_op)
                    plst_pkg::OP_INSERT: begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_addr = plst_pkg::ADDR_W'(r_idx);
                        o_mem_req.wr_data = i_rd_data;
                        n_idx             = r_idx - 7'd1;
                        n_state           = S_RD;
                    end
                    plst_pkg::OP_DELETE: begin
                        o_mem_req.wr_en   = 1'b1;
                        o_mem_req.wr_addr = plst_pkg::ADDR_W'(r_idx - 7'd1);
                        o_mem_req.wr_data = i_rd_data;
                        n_idx             = r_idx + 7'd1;
                        n_state           = S_RD;
                    end
                    plst_pkg::OP_SEARCH: begin
                        // A match waits for the next one or the end to mark the last.
                        if (i_rd_data != r_val) begin
                            n_idx   = r_idx + 7'd1;
                            n_state = S_RD;
                        end else if (!r_have || i_out_free) begin
                            o_emit  = r_have;
                            n_have  = 1'b1;
                            n_pend  = '{status: plst_pkg::ST_OK, entry_total: '0,
                                        found_position: r_idx + 7'd1,
                                        entry_value: i_rd_data, last: 1'b0};
                            n_idx   = r_idx + 7'd1;
                            n_state = S_RD;
                        end
                    end
                    default: begin
                        result = '{status: plst_pkg::ST_OK, entry_total: '0,
                                   found_position: r_idx + 7'd1, entry_value: i_rd_data,
                                   last: (r_idx + 7'd1 == r_count)};
                        if (i_out_free) begin
                            o_emit = 1'b1;
                            n_idx  = r_idx + 7'd1;
                            if (r_idx + 7'd1 == r_count) begin
                                n_state = S_IDLE;
                            end else begin
                                n_state = S_RD;
                            end
                        end
                    end
                endcase
            end

            S_EMIT: begin
                if (i_out_free) begin
                    o_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        result.entry_total = r_count;
        o_result           = result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op   <= n_op;
        r_pos  <= n_pos;
        r_val  <= n_val;
        r_idx  <= n_idx;
        r_have <= n_have;
        r_pend <= n_pend;
    end

    assign o_in_stall = (r_state != S_IDLE);

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= DepthCnt)
    `ASSERT_CLK(a_count_step, i_clk, i_rst_n,
        ($past(i_rst_n) && r_count != $past(r_count)) |->
            (r_count == $past(r_count) + 7'd1 || r_count == $past(r_count) - 7'd1))
    `ASSERT_NEVER(a_no_idle_write, i_clk, i_rst_n,
        r_state == S_IDLE && o_mem_req.wr_en)

endmodule

@@ hw/rtl/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer, entry store and
// the output register. Depends on plst_pkg, plst_seq, plst_store and assert_macros.svh.
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_stall    i_operation, i_position, i_value
//   result    out        o_out_valid / i_out_stall  o_status, o_entry_total,
//                                                   o_found_position, o_entry_value, o_last
//
// One request is worked at a time; o_in_stall is high until its last result
// has been handed to the output register. Each store step is a read, then a write
// or compare, as the store read port is registered. Reset empties the list; a
// stall on the result side simply pauses the walk.
`include "assert_macros.svh"

module positional_list_engine #(
    parameter int LIST_DEPTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [2:0]          i_operation,
    input  logic [6:0]          i_position,
    input  logic signed [31:0]  i_value,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [2:0]          o_status,
    output logic [6:0]          o_entry_total,
    output logic [6:0]          o_found_position,
    output logic signed [31:0]  o_entry_value,
    output logic                o_last
);

    plst_pkg::t_mem_req          mem_req;
    logic [plst_pkg::VAL_W-1:0]  rd_data;
    logic                        emit;
    logic                        out_free;
    plst_pkg::t_result           seq_result;
    plst_pkg::t_result           r_result;
    logic                        r_out_valid;

    assign out_free = !r_out_valid || !i_out_stall;

    plst_seq #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_operation (i_operation),
        .i_position  (i_position),
        .i_value     (i_value),
        .i_rd_data   (rd_data),
        .o_mem_req   (mem_req),
        .i_out_free  (out_free),
        .o_emit      (emit),
        .o_result    (seq_result)
    );

    plst_store #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_mem_req (mem_req),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_result <= seq_result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_result.status;
    assign o_entry_total    = r_result.entry_total;
    assign o_found_position = r_result.found_position;
    assign o_entry_value    = r_result.entry_value;
    assign o_last           = r_result.last;

    // Every error or empty outcome is a single, final transfer.
    `ASSERT_CLK(a_error_is_last, i_clk, i_rst_n,
        (o_out_valid && r_result.status != plst_pkg::ST_OK) |-> o_last)
    // After the last result of a request is emitted, the engine is free for the next.
    `ASSERT_CLK(a_idle_after_last, i_clk, i_rst_n,
        (emit && seq_result.last) |=> !o_in_stall)

endmodule

@@ sim/tb_positional_list_engine.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for positional_list_engine: a directed table and then
// random insert, delete, search, dump, count and unused-code requests with random
// idling. Depends on plst_pkg and the engine RTL only.
module tb_positional_list_engine;

    localparam int LIST_DEPTH   = 32;
    localparam int RANDOM_ITEMS = 250;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 20;
    localparam int HOLD_CYCLES  = 300;
    localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
    localparam logic [2:0] OP_CODE_MAX     = 3'd7;
    localparam logic [6:0] POS_FIELD_MAX   = 7'd127;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [2:0]         i_operation;
    logic [6:0]         i_position;
    logic signed [31:0] i_value;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [2:0]         o_status;
    logic [6:0]         o_entry_total;
    logic [6:0]         o_found_position;
    logic signed [31:0] o_entry_value;
    logic               o_last;

    typedef struct {
        logic [2:0]        op;
        logic [6:0]        pos;
        logic [31:0]       val;
        bit                typed;
        plst_pkg::t_status st;
        logic [6:0]        total;
    } t_directed_row;

    // Rows marked typed carry their single expected result; the others are
    // worked out by the list predictor.
    t_directed_row directed_rows [22] = '{
        '{plst_pkg::OP_COUNT,  7'd0,   32'd0,         1'b1, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_DELETE, 7'd1,   32'd0,         1'b1, plst_pkg::ST_EMPTY,     7'd0},
        '{plst_pkg::OP_SEARCH, 7'd0,   32'd0,         1'b1, plst_pkg::ST_EMPTY,     7'd0},
        '{plst_pkg::OP_DUMP,   7'd0,   32'd0,         1'b1, plst_pkg::ST_EMPTY,     7'd0},
        '{plst_pkg::OP_INSERT, 7'd0,   32'd5,         1'b1, plst_pkg::ST_BAD_POS,   7'd0},
        '{plst_pkg::OP_INSERT, 7'd2,   32'd5,         1'b1, plst_pkg::ST_BAD_POS,   7'd0},
        '{plst_pkg::OP_INSERT, 7'd1,   32'h8000_0000, 1'b1, plst_pkg::ST_OK,        7'd1},
        '{plst_pkg::OP_INSERT, 7'd2,   32'h7FFF_FFFF, 1'b1, plst_pkg::ST_OK,        7'd2},
        '{plst_pkg::OP_INSERT, 7'd1,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_INSERT, 7'd127, 32'hFFFF_FFFF, 1'b1, plst_pkg::ST_BAD_POS,   7'd3},
        '{plst_pkg::OP_INSERT, 7'd4,   32'h7FFF_FFFF, 1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_INSERT, 7'd2,   32'hFFFF_FFFF, 1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_SEARCH, 7'd0,   32'h7FFF_FFFF, 1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_SEARCH, 7'd0,   32'h1234_5678, 1'b1, plst_pkg::ST_NOT_FOUND, 7'd5},
        '{plst_pkg::OP_DUMP,   7'd0,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_DELETE, 7'd0,   32'd0,         1'b1, plst_pkg::ST_BAD_POS,   7'd5},
        '{plst_pkg::OP_DELETE, 7'd6,   32'd0,         1'b1, plst_pkg::ST_BAD_POS,   7'd5},
        '{plst_pkg::OP_DELETE, 7'd5,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_DELETE, 7'd1,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0},
        '{OP_FIRST_UNUSED,     7'd127, 32'hFFFF_FFFF, 1'b0, plst_pkg::ST_OK,        7'd0},
        '{OP_CODE_MAX,         7'd0,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0},
        '{plst_pkg::OP_COUNT,  7'd0,   32'd0,         1'b0, plst_pkg::ST_OK,        7'd0}
    };

    logic [31:0]        list_store [LIST_DEPTH];
    int                 list_count;
    plst_pkg::t_result  step_results [$];
    plst_pkg::t_result  expected_results [$];
    int                 mismatch_count;
    int                 quiet_cycles;
    bit                 steady_phase;

    positional_list_engine #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_position       (i_position),
        .i_value          (i_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_status         (o_status),
        .o_entry_total    (o_entry_total),
        .o_found_position (o_found_position),
        .o_entry_value    (o_entry_value),
        .o_last           (o_last)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Applies one request to the local copy of the list and leaves the
    // results it causes in step_results.
    function automatic void list_step(input logic [2:0] op, input logic [6:0] pos,
                                      input logic [31:0] val);
        plst_pkg::t_result r;
        int                p;
        p = pos;
        step_results.delete();
        r.status         = plst_pkg::ST_OK;
        r.entry_total    = '0;
        r.found_position = '0;
        r.entry_value    = '0;
        r.last           = 1'b1;
        case (op)
            plst_pkg::OP_COUNT: ;
            plst_pkg::OP_INSERT: begin
                if (list_count == LIST_DEPTH) begin
                    r.status = plst_pkg::ST_FULL;
                end else if (p < 1 || p > list_count + 1) begin
                    r.status = plst_pkg::ST_BAD_POS;
                end else begin
                    for (int i = list_count; i >= p; i--)
                        list_store[i] = list_store[i - 1];
                    list_store[p - 1] = val;
                    list_count++;
                end
            end
            plst_pkg::OP_DELETE: begin
                if (list_count == 0) begin
                    r.status = plst_pkg::ST_EMPTY;
                end else if (p < 1 || p > list_count) begin
                    r.status = plst_pkg::ST_BAD_POS;
                end else begin
                    for (int i = p; i < list_count; i++)
                        list_store[i - 1] = list_store[i];
                    list_count--;
                end
            end
            plst_pkg::OP_SEARCH, plst_pkg::OP_DUMP: begin
                r.entry_total = list_count[6:0];
                if (list_count == 0) begin
                    r.status = plst_pkg::ST_EMPTY;
                end else begin
                    for (int i = 0; i < list_count; i++) begin
                        if (op == plst_pkg::OP_DUMP || list_store[i] == val) begin
                            r.found_position = 7'(i + 1);
                            r.entry_value    = list_store[i];
                            r.last           = 1'b0;
                            step_results.push_back(r);
                        end
                    end
                    if (step_results.size() == 0)
                        r.status = plst_pkg::ST_NOT_FOUND;
                    else
                        step_results[step_results.size() - 1].last = 1'b1;
                end
            end
            default: return;
        endcase
        if (step_results.size() == 0) begin
            r.entry_total = list_count[6:0];
            step_results.push_back(r);
        end
    endfunction

    function automatic logic [31:0] pick_value(input bit from_list);
        logic [31:0] pool [6] = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000_0000,
                                  32'h7FFF_FFFF, 32'h5A5A_0001};
        if (from_list && list_count > 0 && $urandom_range(0, 1) == 0)
            return list_store[$urandom_range(0, list_count - 1)];
        if ($urandom_range(0, 2) == 0)
            return pool[$urandom_range(0, 5)];
        return $urandom;
    endfunction

    // Offers one request after a random gap and returns at the edge where it
    // is accepted. Valid stays high when the next request follows at once.
    task automatic send_request(input logic [2:0] op, input logic [6:0] pos,
                                input logic [31:0] val);
        int gap;
        gap = steady_phase ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_operation <= op;
        i_position  <= pos;
        i_value     <= val;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        list_step(op, pos, val);
    endtask

    function automatic void report_field(input string fname, input logic [31:0] want,
                                         input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, fname, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        plst_pkg::t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got status %0d pos %0d",
                         $time, o_status, o_found_position);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                report_field("status", 32'(want.status), 32'(o_status));
                report_field("entry_total", 32'(want.entry_total), 32'(o_entry_total));
                report_field("found_position", 32'(want.found_position),
                             32'(o_found_position));
                report_field("entry_value", want.entry_value, o_entry_value);
                report_field("last", 32'(want.last), 32'(o_last));
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("tb_positional_list_engine: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: a random stall before each transfer, and once a long
    // hold-off so that the engine backs up into its request side.
    initial begin
        int hold;
        int taken;
        bit held_long;
        taken     = 0;
        held_long = 1'b0;
        i_out_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (!held_long && taken >= 40) begin
                held_long = 1'b1;
                hold      = HOLD_CYCLES;
            end else if (steady_phase) begin
                hold = 0;
            end else begin
                hold = $urandom_range(0, 15);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            taken++;
        end
    end

    initial begin
        t_directed_row row;
        int            roll;
        int            issued;
        logic [2:0]    op;
        logic [6:0]    pos;
        logic [31:0]   val;
        bit            growing;

        mismatch_count = 0;
        quiet_cycles   = 0;
        list_count     = 0;
        steady_phase   = 1'b0;
        growing        = 1'b1;
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_operation <= plst_pkg::OP_COUNT;
        i_position  <= '0;
        i_value     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < $size(directed_rows); k++) begin
            row = directed_rows[k];
            send_request(row.op, row.pos, row.val);
            if (row.typed) begin
                expected_results.push_back('{row.st, row.total, 7'd0, 32'd0, 1'b1});
            end else begin
                foreach (step_results[j]) expected_results.push_back(step_results[j]);
            end
        end

        // Random part: phases that grow the list to full and shrink it to empty, with
        // searches, dumps, counts and unused operation codes in between.
        issued = 0;
        while (issued < RANDOM_ITEMS) begin
            if (issued % 50 == 0)
                steady_phase = ($urandom_range(0, 3) == 0);
            if (list_count == LIST_DEPTH)
                growing = 1'b0;
            else if (list_count == 0)
                growing = 1'b1;
            roll = $urandom_range(0, 99);
            if (roll < 95) begin
                if (roll < 55)
                    op = growing ? plst_pkg::OP_INSERT : plst_pkg::OP_DELETE;
                else if (roll < 65)
                    op = growing ? plst_pkg::OP_DELETE : plst_pkg::OP_INSERT;
                else if (roll < 77)
                    op = plst_pkg::OP_SEARCH;
                else if (roll < 85)
                    op = plst_pkg::OP_DUMP;
                else
                    op = plst_pkg::OP_COUNT;
            end else begin
                op = 3'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX));
            end
            pos = 7'($urandom_range(0, POS_FIELD_MAX));
            if (op == plst_pkg::OP_INSERT && $urandom_range(0, 4) != 0)
                pos = 7'($urandom_range(1, list_count + 1));
            else if (op == plst_pkg::OP_DELETE && list_count > 0 && $urandom_range(0, 4) != 0)
                pos = 7'($urandom_range(1, list_count));
            val = pick_value(op == plst_pkg::OP_SEARCH);
            send_request(op, pos, val);
            foreach (step_results[j]) expected_results.push_back(step_results[j]);
            if (op <= plst_pkg::OP_DUMP)
                issued++;
        end
        i_in_valid <= 1'b0;
        steady_phase = 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb_positional_list_engine: done, clean");
        else
            $display("tb_positional_list_engine: done, errors");
        $finish;
    end

endmodule
